@@ hdl/dctd_pkg.sv @@
// Package for the drift circle to track circle distance core.
// Holds the widths and the per-beat data type that the prep stage, the root cells and the
// final stage share. No dependencies.
`default_nettype none

package dctd_pkg;

  localparam int unsigned CoordBits  = 24;
  localparam int unsigned RadiusBits = 16;
  localparam int unsigned DistBits   = 25;

  // Magnitudes of coordinate differences need one bit more than a coordinate.
  localparam int unsigned MagBits  = CoordBits + 1;
  // One root bit is settled per cell, two radicand bits are consumed per cell.
  localparam int unsigned RootBits = MagBits;
  localparam int unsigned RadBits  = 2 * RootBits;
  localparam int unsigned RemBits  = RootBits + 2;
  localparam int unsigned NumCells = RootBits;

  typedef struct packed {
    logic [RadBits-1:0]  rad;
    logic [RemBits-1:0]  rem;
    logic [RootBits-1:0] root;
  } lane_t;

  typedef struct packed {
    lane_t                 rc;
    lane_t                 dc;
    logic [RadiusBits-1:0] rw;
  } cell_t;

endpackage

`default_nettype wire

@@ hdl/drift_circle_track_distance_core.sv @@
// Distance between a track circle through the origin and a hit's drift circle, in units of
// 1/4096 cm. The core is a fixed pipeline that takes one input beat per cycle and gives one
// result beat per input, in order. Each beat passes a front end that forms the magnitudes
// and sums of squares, a chain of 25 square root cells that settle one root bit each and
// work both roots side by side, and a final stage for select and saturation.
// The whole pipeline advances together and holds only while a result beat waits at the
// output, so it keeps accepting while the output is being drained. Depends on dctd_pkg.
`default_nettype none

module drift_circle_track_distance_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [dctd_pkg::CoordBits-1:0]     center_x_i,
  input  logic [dctd_pkg::CoordBits-1:0]     center_y_i,
  input  logic [dctd_pkg::CoordBits-1:0]     wire_x_i,
  input  logic [dctd_pkg::CoordBits-1:0]     wire_y_i,
  input  logic [dctd_pkg::RadiusBits-1:0]    drift_radius_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dctd_pkg::DistBits-1:0]      distance_o
);
  import dctd_pkg::*;

  logic  en;
  logic  chain_valid [NumCells+1];
  cell_t chain_data  [NumCells+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  dctd_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_valid_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .wire_x_i       (wire_x_i),
    .wire_y_i       (wire_y_i),
    .drift_radius_i (drift_radius_i),
    .valid_o        (chain_valid[0]),
    .data_o         (chain_data[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    dctd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  dctd_final u_final (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (chain_valid[NumCells]),
    .data_i     (chain_data[NumCells]),
    .valid_o    (out_valid_o),
    .distance_o (distance_o)
  );

endmodule

`default_nettype wire

@@ hdl/dctd_prep.sv @@
// Front end of the distance core: two pipeline stages that form the coordinate magnitudes
// and then the two sums of squares that feed the root cells. Uses dctd_pkg.
`default_nettype none

module dctd_prep (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [dctd_pkg::CoordBits-1:0]     center_x_i,
  input  logic [dctd_pkg::CoordBits-1:0]     center_y_i,
  input  logic [dctd_pkg::CoordBits-1:0]     wire_x_i,
  input  logic [dctd_pkg::CoordBits-1:0]     wire_y_i,
  input  logic [dctd_pkg::RadiusBits-1:0]    drift_radius_i,
  output logic                               valid_o,
  output dctd_pkg::cell_t                    data_o
);
  import dctd_pkg::*;

  logic                  mag_valid_q;
  logic [MagBits-1:0]    cx_q, cy_q, dx_q, dy_q;
  logic [MagBits-1:0]    cx_d, cy_d, dx_d, dy_d;
  logic [RadiusBits-1:0] rw_q;

  logic                  sq_valid_q;
  cell_t                 sq_q, sq_d;

  logic [RadBits-1:0]    cx2, cy2, dx2, dy2;

  function automatic logic [MagBits-1:0] abs_diff(input logic [CoordBits-1:0] a,
                                                  input logic [CoordBits-1:0] b);
    logic signed [MagBits-1:0] diff;
    diff = $signed({a[CoordBits-1], a}) - $signed({b[CoordBits-1], b});
    return diff[MagBits-1] ? MagBits'(-diff) : MagBits'(diff);
  endfunction

  always_comb begin
    cx_d = abs_diff(center_x_i, '0);
    cy_d = abs_diff(center_y_i, '0);
    dx_d = abs_diff(center_x_i, wire_x_i);
    dy_d = abs_diff(center_y_i, wire_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_valid_q <= 1'b0;
      sq_valid_q  <= 1'b0;
    end else if (en_i) begin
      mag_valid_q <= valid_i;
      sq_valid_q  <= mag_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
      rw_q <= drift_radius_i;
      sq_q <= sq_d;
    end
  end

  // Each square is at most 2^48, so the sum of two still fits the radicand width.
  always_comb begin
    cx2 = RadBits'(cx_q) * RadBits'(cx_q);
    cy2 = RadBits'(cy_q) * RadBits'(cy_q);
    dx2 = RadBits'(dx_q) * RadBits'(dx_q);
    dy2 = RadBits'(dy_q) * RadBits'(dy_q);

    sq_d         = '0;
    sq_d.rc.rad  = cx2 + cy2;
    sq_d.dc.rad  = dx2 + dy2;
    sq_d.rw      = rw_q;
  end

  assign valid_o = sq_valid_q;
  assign data_o  = sq_q;

endmodule

`default_nettype wire

@@ hdl/dctd_cell.sv @@
// One cell of the square root chain: settles one root bit for the track radius lane and one
// for the centre distance lane, then registers the beat for the next cell. Uses dctd_pkg.
`default_nettype none

module dctd_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  dctd_pkg::cell_t data_i,
  output logic            valid_o,
  output dctd_pkg::cell_t data_o
);
  import dctd_pkg::*;

  logic  valid_q;
  cell_t data_q, data_d;

  // Restoring digit-by-digit step: bring down the next two radicand bits and try a one.
  function automatic lane_t root_step(input lane_t l);
    logic [RemBits+1:0] acc;
    logic [RemBits+1:0] trial;
    lane_t              r;
    acc   = {l.rem, l.rad[RadBits-1 -: 2]};
    trial = {2'b00, l.root, 2'b01};
    r.rad = {l.rad[RadBits-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = RemBits'(acc - trial);
      r.root = {l.root[RootBits-2:0], 1'b1};
    end else begin
      r.rem  = RemBits'(acc);
      r.root = {l.root[RootBits-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    data_d.rc = root_step(data_i.rc);
    data_d.dc = root_step(data_i.dc);
    data_d.rw = data_i.rw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ hdl/dctd_final.sv @@
// Final stage of the distance core: picks the sum or the difference of the radii, takes the
// absolute gap to the centre distance, saturates and holds the result beat. Uses dctd_pkg.
`default_nettype none

module dctd_final (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  dctd_pkg::cell_t               data_i,
  output logic                          valid_o,
  output logic [dctd_pkg::DistBits-1:0] distance_o
);
  import dctd_pkg::*;

  localparam int unsigned WideBits = RootBits + 1;

  logic                valid_q;
  logic [DistBits-1:0] dist_q, dist_d;

  logic [WideBits-1:0] rc, rw, dc;
  logic [WideBits-1:0] sum_r, dif_r, big, ref_r, gap;

  always_comb begin
    rc    = WideBits'(data_i.rc.root);
    dc    = WideBits'(data_i.dc.root);
    rw    = WideBits'(data_i.rw);
    sum_r = rc + rw;
    dif_r = (rc >= rw) ? rc - rw : rw - rc;
    big   = (rc >= rw) ? rc : rw;
    // A tie with the larger radius falls to the difference of the radii.
    ref_r = (dc > big) ? sum_r : dif_r;
    gap   = (dc >= ref_r) ? dc - ref_r : ref_r - dc;
    if (gap > WideBits'({DistBits{1'b1}})) begin
      dist_d = '1;
    end else begin
      dist_d = DistBits'(gap);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= dist_d;
    end
  end

  assign valid_o    = valid_q;
  assign distance_o = dist_q;

endmodule

`default_nettype wire
